### rtl/lpna_pkg.sv
package lpna_pkg;

    localparam int IDX_IN_W = 10;
    localparam int FIELD_W  = 16;

    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_VERTEX = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;

    // Largest unit component, 1.0 in Q1.14
    localparam logic signed [FIELD_W-1:0] UNIT_ONE = 16'sd16384;

    typedef struct packed {
        logic [1:0]                 req_type;
        logic [IDX_IN_W-1:0]        point_index;
        logic signed [FIELD_W-1:0]  coord_x;
        logic signed [FIELD_W-1:0]  coord_y;
        logic                       line_start;
    } req_t;

    typedef struct packed {
        logic [IDX_IN_W-1:0]        out_index;
        logic signed [FIELD_W-1:0]  normal_x;
        logic signed [FIELD_W-1:0]  normal_y;
        logic                       zero_length;
    } res_t;

    // Status returned by the normalising unit
    typedef struct packed {
        logic                       valid;
        logic signed [FIELD_W-1:0]  normal_x;
        logic signed [FIELD_W-1:0]  normal_y;
        logic                       zero_length;
    } unit_res_t;

endpackage

### rtl/lpna_norm_unit.sv
module lpna_norm_unit #(
    parameter int ACC_BITS = 28
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       go,
    input  logic signed [ACC_BITS-1:0] sum_x,
    input  logic signed [ACC_BITS-1:0] sum_y,
    output lpna_pkg::unit_res_t        res
);
    import lpna_pkg::*;

    localparam logic [2:0] U_IDLE  = 3'd0;
    localparam logic [2:0] U_SHIFT = 3'd1;
    localparam logic [2:0] U_SQA   = 3'd2;
    localparam logic [2:0] U_SQB   = 3'd3;
    localparam logic [2:0] U_SUM   = 3'd4;
    localparam logic [2:0] U_DIV   = 3'd5;
    localparam logic [2:0] U_SQRT  = 3'd6;
    localparam logic [2:0] U_FIN   = 3'd7;

    localparam logic [4:0] DIV_LAST_BIT = 5'd30;
    localparam logic [4:0] SQRT_LAST    = 5'd15;

    logic [2:0]                state_reg, state_next;
    logic [ACC_BITS-1:0]       a_reg, a_next, b_reg, b_next;
    logic                      neg_x_reg, neg_x_next, neg_y_reg, neg_y_next;
    logic [29:0]               a2_reg, a2_next, b2_reg, b2_next;
    logic [30:0]               s_reg, s_next;
    logic [30:0]               rem_reg, rem_next;
    logic [30:0]               q_reg, q_next;
    logic [4:0]                cnt_reg, cnt_next;
    logic                      comp_reg, comp_next;
    logic [31:0]               x_reg, x_next;
    logic [15:0]               root_reg, root_next;
    logic [19:0]               srem_reg, srem_next;
    logic signed [FIELD_W-1:0] nx_reg, nx_next, ny_reg, ny_next;
    logic                      zl_reg, zl_next;
    logic                      valid_reg, valid_next;

    logic [31:0]               div_sh;
    logic [31:0]               div_s;
    logic                      div_bit;
    logic [30:0]               div_rem;
    logic [19:0]               sq_sh;
    logic [19:0]               sq_trial;
    logic                      sq_bit;
    logic [16:0]               mag_sum;
    logic [FIELD_W-1:0]        mag;
    logic signed [FIELD_W-1:0] comp_val;

    always_comb
    begin
        div_sh  = (cnt_reg == DIV_LAST_BIT) ? {1'b0, rem_reg} : {rem_reg, 1'b0};
        div_s   = {1'b0, s_reg};
        div_bit = (div_sh >= div_s);
        div_rem = div_bit ? 31'(div_sh - div_s) : div_sh[30:0];

        sq_sh    = {srem_reg[17:0], x_reg[31:30]};
        sq_trial = {2'b00, root_reg, 2'b01};
        sq_bit   = (sq_sh >= sq_trial);

        // Round half up: ceil of the doubled root over two
        mag_sum  = {1'b0, root_reg} + 17'd1;
        mag      = mag_sum[16:1];
        comp_val = (comp_reg ? neg_y_reg : neg_x_reg) ? -$signed(mag) : $signed(mag);
    end

    always_comb
    begin
        state_next = state_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        neg_x_next = neg_x_reg;
        neg_y_next = neg_y_reg;
        a2_next    = a2_reg;
        b2_next    = b2_reg;
        s_next     = s_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        comp_next  = comp_reg;
        x_next     = x_reg;
        root_next  = root_reg;
        srem_next  = srem_reg;
        nx_next    = nx_reg;
        ny_next    = ny_reg;
        zl_next    = zl_reg;
        valid_next = 1'b0;

        case (state_reg)
            U_IDLE:
            begin
                if (go)
                begin
                    neg_x_next = sum_x[ACC_BITS-1];
                    neg_y_next = sum_y[ACC_BITS-1];
                    a_next     = sum_x[ACC_BITS-1] ? ACC_BITS'(-sum_x) : ACC_BITS'(sum_x);
                    b_next     = sum_y[ACC_BITS-1] ? ACC_BITS'(-sum_y) : ACC_BITS'(sum_y);
                    if (sum_x == '0 && sum_y == '0)
                    begin
                        nx_next    = '0;
                        ny_next    = '0;
                        zl_next    = 1'b1;
                        valid_next = 1'b1;
                    end
                    else
                    begin
                        zl_next    = 1'b0;
                        state_next = U_SHIFT;
                    end
                end
            end
            U_SHIFT:
            begin
                // Halve both until they fit in 15 bits
                if ((|a_reg[ACC_BITS-1:15]) || (|b_reg[ACC_BITS-1:15]))
                begin
                    a_next = a_reg >> 1;
                    b_next = b_reg >> 1;
                end
                else
                begin
                    state_next = U_SQA;
                end
            end
            U_SQA:
            begin
                a2_next    = a_reg[14:0] * a_reg[14:0];
                state_next = U_SQB;
            end
            U_SQB:
            begin
                b2_next    = b_reg[14:0] * b_reg[14:0];
                state_next = U_SUM;
            end
            U_SUM:
            begin
                s_next     = {1'b0, a2_reg} + {1'b0, b2_reg};
                rem_next   = {1'b0, a2_reg};
                q_next     = '0;
                cnt_next   = DIV_LAST_BIT;
                comp_next  = 1'b0;
                state_next = U_DIV;
            end
            U_DIV:
            begin
                // One quotient bit of c*c*2^30 / s per cycle
                rem_next = div_rem;
                q_next   = {q_reg[29:0], div_bit};
                if (cnt_reg == '0)
                begin
                    x_next     = {1'b0, q_reg[29:0], div_bit};
                    root_next  = '0;
                    srem_next  = '0;
                    cnt_next   = SQRT_LAST;
                    state_next = U_SQRT;
                end
                else
                begin
                    cnt_next = cnt_reg - 5'd1;
                end
            end
            U_SQRT:
            begin
                // One root bit per cycle
                x_next = {x_reg[29:0], 2'b00};
                if (sq_bit)
                begin
                    srem_next = sq_sh - sq_trial;
                    root_next = {root_reg[14:0], 1'b1};
                end
                else
                begin
                    srem_next = sq_sh;
                    root_next = {root_reg[14:0], 1'b0};
                end
                if (cnt_reg == '0)
                    state_next = U_FIN;
                else
                    cnt_next = cnt_reg - 5'd1;
            end
            U_FIN:
            begin
                if (!comp_reg)
                begin
                    nx_next    = comp_val;
                    comp_next  = 1'b1;
                    rem_next   = {1'b0, b2_reg};
                    q_next     = '0;
                    cnt_next   = DIV_LAST_BIT;
                    state_next = U_DIV;
                end
                else
                begin
                    ny_next    = comp_val;
                    valid_next = 1'b1;
                    state_next = U_IDLE;
                end
            end
            default:
            begin
                state_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        neg_x_reg <= neg_x_next;
        neg_y_reg <= neg_y_next;
        a2_reg    <= a2_next;
        b2_reg    <= b2_next;
        s_reg     <= s_next;
        rem_reg   <= rem_next;
        q_reg     <= q_next;
        cnt_reg   <= cnt_next;
        comp_reg  <= comp_next;
        x_reg     <= x_next;
        root_reg  <= root_next;
        srem_reg  <= srem_next;
        nx_reg    <= nx_next;
        ny_reg    <= ny_next;
        zl_reg    <= zl_next;
    end

    assign res.valid       = valid_reg;
    assign res.normal_x    = nx_reg;
    assign res.normal_y    = ny_reg;
    assign res.zero_length = zl_reg;

endmodule

### rtl/line_point_normal_accumulator_top.sv
// Line/point normal accumulator.
// Request channel: a transaction is taken on a rising edge with start high and
// busy low. A load writes a point's coordinates and clears its accumulated
// normal; a vertex builds line normals and adds them into the accumulators of
// the line's points; a read returns the point's normal scaled to unit length.
// Result channel: done is high for one cycle with the result of a read; there
// is no back-pressure, the receiver must take it in that cycle.
// Steps: a load, a line start or an ignored request completes when taken. A later
// vertex of a line does an accumulator read, then a write back through the
// accumulator memory. A line's second vertex does two coordinate reads plus
// two read-modify-write passes. A read of a point whose sums are both zero
// is reported as zero length by the normalising unit; else the unit halves the
// sums until they fit, squares and adds them, then per component runs a divide
// and a square root. The result appears in the same cycle as busy drops.
// Reset: the accumulator memory is swept to zero, entry by entry, with busy
// high. The line state clears at once; coordinates stay undefined until loaded.
module line_point_normal_accumulator_top #(
    parameter int MAX_POINTS = 1024,
    parameter int COORD_BITS = 16,
    parameter int ACC_BITS   = 28
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  lpna_pkg::req_t req,
    output logic           done,
    output lpna_pkg::res_t result
);
    import lpna_pkg::*;

    localparam int IDX_W   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int NRM_W   = COORD_BITS + 1;
    localparam int SUM_W   = ((ACC_BITS > NRM_W) ? ACC_BITS : NRM_W) + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_POINTS - 1);
    localparam logic signed [SUM_W-1:0] ACC_MAX =
        SUM_W'((64'sd1 <<< (ACC_BITS - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] ACC_MIN = -ACC_MAX - SUM_W'(1);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_V_C1   = 3'd2;
    localparam logic [2:0] ST_V_C2   = 3'd3;
    localparam logic [2:0] ST_ACC_RD = 3'd4;
    localparam logic [2:0] ST_ACC_WR = 3'd5;
    localparam logic [2:0] ST_RD     = 3'd6;
    localparam logic [2:0] ST_UNIT   = 3'd7;

    function automatic logic [IDX_W-1:0] reduce_idx(input logic [IDX_IN_W-1:0] v);
        logic [31:0] r;
        logic [31:0] lim;
        r = 32'(v);
        for (int k = IDX_IN_W - 1; k >= 0; k--)
        begin
            lim = 32'(MAX_POINTS) << k;
            if (lim < (32'd1 << IDX_IN_W) && r >= lim)
                r = r - lim;
        end
        return IDX_W'(r);
    endfunction

    logic [2*COORD_BITS-1:0] coord_mem [MAX_POINTS];
    logic [2*ACC_BITS-1:0]   acc_mem   [MAX_POINTS];

    logic [2:0]              state_reg, state_next;
    logic [IDX_W-1:0]        clr_reg, clr_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [IDX_W-1:0]        addr_reg, addr_next;
    logic                    second_reg, second_next;
    logic [IDX_W-1:0]        first_reg, first_next;
    logic [1:0]              count_reg, count_next;
    logic signed [NRM_W-1:0] line_nx_reg, line_nx_next;
    logic signed [NRM_W-1:0] line_ny_reg, line_ny_next;
    logic signed [COORD_BITS-1:0] p2x_reg, p2x_next, p2y_reg, p2y_next;
    logic                    done_reg, done_next;
    res_t                    result_reg, result_next;

    logic                    accept;
    logic [IDX_W-1:0]        in_idx;
    logic [IDX_W-1:0]        coord_raddr;
    logic [2*COORD_BITS-1:0] coord_rdata;
    logic                    coord_we;
    logic [IDX_W-1:0]        acc_raddr;
    logic [2*ACC_BITS-1:0]   acc_rdata;
    logic                    acc_we;
    logic [IDX_W-1:0]        acc_waddr;
    logic [2*ACC_BITS-1:0]   acc_wdata;
    logic                    unit_go;
    unit_res_t               unit_res;

    logic signed [COORD_BITS-1:0] rd_x, rd_y;
    logic signed [ACC_BITS-1:0]   rd_sx, rd_sy;
    logic signed [SUM_W-1:0]      add_x, add_y;
    logic signed [ACC_BITS-1:0]   new_sx, new_sy;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);
    assign in_idx = reduce_idx(req.point_index);

    always_comb
    begin
        rd_x  = coord_rdata[COORD_BITS-1:0];
        rd_y  = coord_rdata[2*COORD_BITS-1:COORD_BITS];
        rd_sx = acc_rdata[ACC_BITS-1:0];
        rd_sy = acc_rdata[2*ACC_BITS-1:ACC_BITS];
        add_x = SUM_W'(rd_sx) + SUM_W'(line_nx_reg);
        add_y = SUM_W'(rd_sy) + SUM_W'(line_ny_reg);
        if (add_x > ACC_MAX)
            new_sx = ACC_BITS'(ACC_MAX);
        else if (add_x < ACC_MIN)
            new_sx = ACC_BITS'(ACC_MIN);
        else
            new_sx = ACC_BITS'(add_x);
        if (add_y > ACC_MAX)
            new_sy = ACC_BITS'(ACC_MAX);
        else if (add_y < ACC_MIN)
            new_sy = ACC_BITS'(ACC_MIN);
        else
            new_sy = ACC_BITS'(add_y);
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        idx_next     = idx_reg;
        addr_next    = addr_reg;
        second_next  = second_reg;
        first_next   = first_reg;
        count_next   = count_reg;
        line_nx_next = line_nx_reg;
        line_ny_next = line_ny_reg;
        p2x_next     = p2x_reg;
        p2y_next     = p2y_reg;
        done_next    = 1'b0;
        result_next  = result_reg;
        coord_raddr  = in_idx;
        coord_we     = 1'b0;
        acc_raddr    = in_idx;
        acc_we       = 1'b0;
        acc_waddr    = in_idx;
        acc_wdata    = '0;
        unit_go      = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                acc_we    = 1'b1;
                acc_waddr = clr_reg;
                if (clr_reg == LAST_IDX)
                    state_next = ST_IDLE;
                else
                    clr_next = clr_reg + IDX_W'(1);
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    idx_next = in_idx;
                    case (req.req_type)
                        REQ_LOAD:
                        begin
                            coord_we = 1'b1;
                            acc_we   = 1'b1;
                        end
                        REQ_VERTEX:
                        begin
                            if (req.line_start)
                            begin
                                first_next   = in_idx;
                                count_next   = 2'd1;
                                line_nx_next = '0;
                                line_ny_next = '0;
                            end
                            else if (count_reg == 2'd1)
                            begin
                                state_next = ST_V_C1;
                            end
                            else if (count_reg == 2'd2)
                            begin
                                // Accumulator read already issued for this index
                                addr_next   = in_idx;
                                second_next = 1'b0;
                                state_next  = ST_ACC_WR;
                            end
                        end
                        REQ_READ:
                        begin
                            state_next = ST_RD;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_V_C1:
            begin
                p2x_next    = rd_x;
                p2y_next    = rd_y;
                coord_raddr = first_reg;
                state_next  = ST_V_C2;
            end
            ST_V_C2:
            begin
                // Normal is (dy, -dx) from the first vertex to this one
                line_nx_next = NRM_W'(p2y_reg) - NRM_W'(rd_y);
                line_ny_next = NRM_W'(rd_x) - NRM_W'(p2x_reg);
                count_next   = 2'd2;
                addr_next    = first_reg;
                second_next  = 1'b1;
                state_next   = ST_ACC_RD;
            end
            ST_ACC_RD:
            begin
                acc_raddr  = addr_reg;
                state_next = ST_ACC_WR;
            end
            ST_ACC_WR:
            begin
                acc_we    = 1'b1;
                acc_waddr = addr_reg;
                acc_wdata = {new_sy, new_sx};
                // Write lands before the second read is issued, so no forwarding
                if (second_reg)
                begin
                    second_next = 1'b0;
                    addr_next   = idx_reg;
                    state_next  = ST_ACC_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RD:
            begin
                unit_go    = 1'b1;
                state_next = ST_UNIT;
            end
            ST_UNIT:
            begin
                if (unit_res.valid)
                begin
                    done_next               = 1'b1;
                    result_next.out_index   = IDX_IN_W'(idx_reg);
                    result_next.normal_x    = unit_res.normal_x;
                    result_next.normal_y    = unit_res.normal_y;
                    result_next.zero_length = unit_res.zero_length;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (coord_we)
            coord_mem[acc_waddr] <= {COORD_BITS'(req.coord_y), COORD_BITS'(req.coord_x)};
        coord_rdata <= coord_mem[coord_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (acc_we)
            acc_mem[acc_waddr] <= acc_wdata;
        acc_rdata <= acc_mem[acc_raddr];
    end

    lpna_norm_unit #(
        .ACC_BITS (ACC_BITS)
    ) u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (unit_go),
        .sum_x (rd_sx),
        .sum_y (rd_sy),
        .res   (unit_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            first_reg   <= '0;
            count_reg   <= 2'd0;
            line_nx_reg <= '0;
            line_ny_reg <= '0;
            second_reg  <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            first_reg   <= first_next;
            count_reg   <= count_next;
            line_nx_reg <= line_nx_next;
            line_ny_reg <= line_ny_next;
            second_reg  <= second_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        addr_reg   <= addr_next;
        p2x_reg    <= p2x_next;
        p2y_reg    <= p2y_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_done_after_unit: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg) == ST_UNIT)
        else $error("result strobe without a finished normalisation");

    a_unit_only_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        unit_res.valid |-> state_reg == ST_UNIT)
        else $error("normalising unit finished with no read pending");

    a_zero_length_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.zero_length |-> result.normal_x == '0 && result.normal_y == '0)
        else $error("zero-length result carries a non-zero component");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.normal_x <= UNIT_ONE && result.normal_x >= -UNIT_ONE
              && result.normal_y <= UNIT_ONE && result.normal_y >= -UNIT_ONE)
        else $error("normal component outside unit range");

endmodule

### tb/sv/line_point_normal_accumulator_top_tb.sv
module line_point_normal_accumulator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lpna_pkg::*;

    localparam int  POINTS     = 1024;
    localparam int  SUM_BITS   = 28;
    localparam int  HAMMER_LEN = 300;
    localparam int  TOTAL_REQS = 1750;
    localparam int  CYCLE_CAP  = 2000000;
    localparam logic [1:0] REQ_NONE = 2'd3;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    req_t req;
    logic done;
    res_t result;

    req_t pending_reqs[$];
    res_t normal_expect[$];
    int   error_count;
    int   accepted_count;
    int   cycle_count;

    // predictor state
    logic signed [15:0] coord_xs[POINTS];
    logic signed [15:0] coord_ys[POINTS];
    longint             acc_xs[POINTS];
    longint             acc_ys[POINTS];
    int                 line_first;
    int                 line_vertices;
    longint             line_norm_x;
    longint             line_norm_y;

    // generator state
    int loaded_points[$];

    line_point_normal_accumulator_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .req    (req),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint saturate_sum(longint a, longint b);
        longint hi;
        longint s;
        hi = (longint'(1) << (SUM_BITS - 1)) - 1;
        s  = a + b;
        if (s > hi)
            return hi;
        if (s < -hi - 1)
            return -hi - 1;
        return s;
    endfunction

    // round-half-up of 16384*c/sqrt(s), solved exactly by bitwise search
    function automatic longint unsigned unit_scale(longint unsigned c, longint unsigned s);
        longint unsigned target;
        longint unsigned n;
        longint unsigned cand;
        longint unsigned probe;
        target = (c * c) << 28;
        n = 0;
        probe = 64'd1 << 14;
        while (probe != 0)
        begin
            cand = n | probe;
            if (cand * cand * s <= target)
                n = cand;
            probe = probe >> 1;
        end
        if ((2 * n + 1) * (2 * n + 1) * s <= (target << 2))
            n = n + 1;
        return n;
    endfunction

    task automatic add_line_normal(int p);
        acc_xs[p] = saturate_sum(acc_xs[p], line_norm_x);
        acc_ys[p] = saturate_sum(acc_ys[p], line_norm_y);
    endtask

    task automatic predict_normal(req_t r);
        int              idx;
        longint unsigned a;
        longint unsigned b;
        longint unsigned s;
        longint unsigned ma;
        longint unsigned mb;
        res_t            exp_res;
        idx = int'(r.point_index);
        case (r.req_type)
            REQ_LOAD:
            begin
                coord_xs[idx] = r.coord_x;
                coord_ys[idx] = r.coord_y;
                acc_xs[idx] = 0;
                acc_ys[idx] = 0;
            end
            REQ_VERTEX:
            begin
                if (r.line_start)
                begin
                    line_first    = idx;
                    line_vertices = 1;
                    line_norm_x   = 0;
                    line_norm_y   = 0;
                end
                else if (line_vertices == 1)
                begin
                    line_norm_x = longint'(coord_ys[idx]) - longint'(coord_ys[line_first]);
                    line_norm_y = longint'(coord_xs[line_first]) - longint'(coord_xs[idx]);
                    add_line_normal(line_first);
                    add_line_normal(idx);
                    line_vertices = 2;
                end
                else if (line_vertices == 2)
                    add_line_normal(idx);
            end
            REQ_READ:
            begin
                exp_res = '0;
                exp_res.out_index = r.point_index;
                if (acc_xs[idx] == 0 && acc_ys[idx] == 0)
                    exp_res.zero_length = 1'b1;
                else
                begin
                    a = (acc_xs[idx] < 0) ? -acc_xs[idx] : acc_xs[idx];
                    b = (acc_ys[idx] < 0) ? -acc_ys[idx] : acc_ys[idx];
                    while (a >= (64'd1 << 15) || b >= (64'd1 << 15))
                    begin
                        a = a >> 1;
                        b = b >> 1;
                    end
                    s  = a * a + b * b;
                    ma = unit_scale(a, s);
                    mb = unit_scale(b, s);
                    exp_res.normal_x = (acc_xs[idx] < 0) ? -16'(ma) : 16'(ma);
                    exp_res.normal_y = (acc_ys[idx] < 0) ? -16'(mb) : 16'(mb);
                end
                normal_expect.push_back(exp_res);
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic queue_req(logic [1:0] kind, int idx, int x, int y, bit ls);
        req_t r;
        r.req_type    = kind;
        r.point_index = idx[9:0];
        r.coord_x     = x[15:0];
        r.coord_y     = y[15:0];
        r.line_start  = ls;
        pending_reqs.push_back(r);
    endtask

    task automatic queue_load(int idx, int x, int y);
        queue_req(REQ_LOAD, idx, x, y, 1'b0);
        loaded_points.push_back(idx);
    endtask

    // vertex and read fields that are unused still carry random bits
    task automatic queue_vertex(int idx, bit ls);
        queue_req(REQ_VERTEX, idx, $urandom, $urandom, ls);
    endtask

    task automatic queue_read(int idx);
        queue_req(REQ_READ, idx, $urandom, $urandom, $urandom_range(1));
    endtask

    function automatic int pick_loaded();
        return loaded_points[$urandom_range(loaded_points.size() - 1)];
    endfunction

    task automatic build_stimulus();
        int n_verts;
        int choice;
        int idx;
        // directed part
        queue_vertex(0, 1'b0);
        queue_load(0, -32768, -32768);
        queue_load(1023, 32767, 32767);
        queue_load(5, 0, 0);
        queue_load(7, 0, 100);
        queue_req(REQ_NONE, 1023, $urandom, $urandom, 1'b1);
        queue_read(1023);
        queue_vertex(0, 1'b1);
        queue_vertex(1023, 1'b0);
        queue_vertex(5, 1'b0);
        queue_vertex(5, 1'b0);
        queue_read(0);
        queue_read(1023);
        queue_read(5);
        // single-vertex lines add nothing
        queue_vertex(5, 1'b1);
        queue_vertex(0, 1'b1);
        queue_read(0);
        queue_load(0, 0, 100);
        queue_read(0);
        queue_vertex(5, 1'b1);
        queue_vertex(7, 1'b0);
        queue_read(7);
        // drive one point to large sums on both axes
        queue_load(10, -32768, -32768);
        queue_load(11, 32767, 32767);
        queue_vertex(10, 1'b1);
        queue_vertex(11, 1'b0);
        repeat (HAMMER_LEN)
            queue_vertex(11, 1'b0);
        queue_read(11);
        queue_read(10);

        // random part
        while (pending_reqs.size() < TOTAL_REQS)
        begin
            choice = $urandom_range(99);
            idx = ($urandom_range(3) == 0) ? $urandom_range(POINTS - 1) : $urandom_range(63);
            if (choice < 15)
                queue_load(idx, $urandom, $urandom);
            else if (choice < 27)
                queue_read(($urandom_range(1) == 0) ? pick_loaded() : idx);
            else if (choice < 32)
            begin
                if ($urandom_range(1) == 0)
                    queue_req(REQ_NONE, idx, $urandom, $urandom, $urandom_range(1));
                else
                    queue_vertex(pick_loaded(), $urandom_range(1));
            end
            else
            begin
                n_verts = $urandom_range(6, 1);
                queue_vertex(pick_loaded(), 1'b1);
                repeat (n_verts - 1)
                    queue_vertex(pick_loaded(), 1'b0);
                if ($urandom_range(1) == 0)
                    queue_read(pick_loaded());
            end
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            req   <= '0;
        end
        else if (start && busy)
        begin
            // hold the offered transaction
        end
        else
        begin
            if (start)
            begin
                predict_normal(req);
                void'(pending_reqs.pop_front());
                accepted_count++;
            end
            if (pending_reqs.size() > 0 &&
                !((accepted_count < 600 || accepted_count > 900) && $urandom_range(99) < 31))
            begin
                start <= 1'b1;
                req   <= pending_reqs[0];
            end
            else
                start <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (normal_expect.size() == 0)
            begin
                $error("unexpected result for index %0d", result.out_index);
                error_count++;
            end
            else
            begin
                if (result.out_index !== normal_expect[0].out_index)
                begin
                    $error("out_index: expected %0d, actual %0d",
                           normal_expect[0].out_index, result.out_index);
                    error_count++;
                end
                if (result.normal_x !== normal_expect[0].normal_x)
                begin
                    $error("normal_x: expected %0d, actual %0d",
                           normal_expect[0].normal_x, result.normal_x);
                    error_count++;
                end
                if (result.normal_y !== normal_expect[0].normal_y)
                begin
                    $error("normal_y: expected %0d, actual %0d",
                           normal_expect[0].normal_y, result.normal_y);
                    error_count++;
                end
                if (result.zero_length !== normal_expect[0].zero_length)
                begin
                    $error("zero_length: expected %0d, actual %0d",
                           normal_expect[0].zero_length, result.zero_length);
                    error_count++;
                end
                void'(normal_expect.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_CAP)
        begin
            $display("[line_point_normal_accumulator_top] ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        req            = '0;
        error_count    = 0;
        accepted_count = 0;
        cycle_count    = 0;
        line_first     = 0;
        line_vertices  = 0;
        line_norm_x    = 0;
        line_norm_y    = 0;
        for (int i = 0; i < POINTS; i++)
        begin
            coord_xs[i] = '0;
            coord_ys[i] = '0;
            acc_xs[i]   = 0;
            acc_ys[i]   = 0;
        end
        build_stimulus();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        while (pending_reqs.size() > 0 || start || normal_expect.size() > 0)
            @(posedge clk);
        // let a late read drain
        repeat (200) @(posedge clk);
        if (error_count == 0 && normal_expect.size() == 0)
            $display("[line_point_normal_accumulator_top] OK");
        else
            $display("[line_point_normal_accumulator_top] ERROR");
        $finish;
    end

endmodule
